### rtl/core/ubxfp_pkg.sv
package ubxfp_pkg;

	localparam int MESSAGE_TYPES = 9;
	localparam int TABLE_ENTRIES = 9;
	localparam int CNT_ENTRIES   = MESSAGE_TYPES + 1;
	localparam int CNT_ADDR_W    = $clog2(CNT_ENTRIES);
	localparam int CNT_W         = 32;

	localparam logic [7:0]  SYNC_FIRST  = 8'hB5;
	localparam logic [7:0]  SYNC_SECOND = 8'h62;
	localparam logic [15:0] LIMIT_RESET = 16'd100;

	localparam logic [7:0] KNOWN_CLASS [TABLE_ENTRIES] = '{
		8'h0A, 8'h0D, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h0A, 8'h27
	};
	localparam logic [7:0] KNOWN_ID [TABLE_ENTRIES] = '{
		8'h09, 8'h01, 8'h07, 8'h36, 8'h04, 8'h03, 8'h11, 8'h39, 8'h09
	};

	typedef enum logic [3:0] {
		PH_HUNT1,
		PH_HUNT2,
		PH_CLASS,
		PH_ID,
		PH_LEN_LO,
		PH_LEN_HI,
		PH_PAYLOAD,
		PH_CK_A,
		PH_CK_B
	} phase_t;

	typedef enum logic [2:0] {
		EV_NONE,
		EV_KNOWN,
		EV_UNKNOWN,
		EV_CKSUM,
		EV_BADLEN
	} event_t;

	typedef struct packed {
		event_t       frame_event;
		logic [3:0]   message_index;
		logic         payload_valid;
		logic [7:0]   payload_byte;
		logic [15:0]  payload_offset;
		logic [CNT_W-1:0] message_count;
	} res_t;

	// Returns the first matching table entry, or MESSAGE_TYPES for an unknown pair.
	function automatic logic [CNT_ADDR_W-1:0] find_message(input logic [7:0] cls,
		input logic [7:0] id);
		logic [CNT_ADDR_W-1:0] idx;
		idx = CNT_ADDR_W'(MESSAGE_TYPES);
		for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
			if (i < MESSAGE_TYPES && KNOWN_CLASS[i] == cls && KNOWN_ID[i] == id) begin
				idx = CNT_ADDR_W'(i);
			end
		end
		return idx;
	endfunction

endpackage

### rtl/core/ubx_frame_parser.sv
// Channel   Handshake            Payload
// rx        rx_valid/rx_ready    rx_byte
// res       res_valid/res_ready  frame_event, message_index, payload_valid,
//                                payload_byte, payload_offset, message_count
// cfg       cfg_wr_en            cfg_wr_data (payload length limit)
//
// One received byte is taken every cycle while rx_ready is high and yields one result
// beat, which the accepting edge loads into the output register unless the output stalls.
// The frame counters live in a small memory: the first checksum byte issues the
// read and the second writes the incremented count back, so the memory port never
// stalls the input. Reset clears the counter valid bits at once; there is no
// clearing pass. A two-entry output buffer keeps rx_ready high while one result
// waits, so a stalled output holds the input only when both entries fill.
module ubx_frame_parser import ubxfp_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_wr_en,
	input  logic [15:0]  cfg_wr_data,
	input  logic         rx_valid,
	output logic         rx_ready,
	input  logic [7:0]   rx_byte,
	output logic         res_valid,
	input  logic         res_ready,
	output logic [2:0]   frame_event,
	output logic [3:0]   message_index,
	output logic         payload_valid,
	output logic [7:0]   payload_byte,
	output logic [15:0]  payload_offset,
	output logic [31:0]  message_count
);

	phase_t phase_q, phase_d;
	logic [15:0] limit_q;
	logic [7:0]  class_q;
	logic [15:0] len_q;
	logic [15:0] pos_q;
	logic [7:0]  sum_a_q;
	logic [7:0]  sum_b_q;
	logic [7:0]  rcv_a_q;
	logic [CNT_ADDR_W-1:0] idx_q;
	logic [CNT_ENTRIES-1:0] cnt_valid_q;
	logic        rd_valid_q;

	logic        rx_fire;
	logic [7:0]  add_a;
	logic [7:0]  add_b;
	logic [15:0] len_full;
	logic [15:0] pos_next;
	logic        ck_ok;
	logic        known;
	logic [CNT_W-1:0] ram_rd_data;
	logic [CNT_W-1:0] count_new;
	logic        ram_rd_en;
	logic        ram_wr_en;
	res_t        res_d;
	res_t        res_out;

	assign rx_fire   = rx_valid && rx_ready;
	assign add_a     = sum_a_q + rx_byte;
	assign add_b     = sum_b_q + add_a;
	assign len_full  = {rx_byte, len_q[7:0]};
	assign pos_next  = pos_q + 16'd1;
	assign ck_ok     = (rcv_a_q == sum_a_q) && (rx_byte == sum_b_q);
	assign known     = idx_q != CNT_ADDR_W'(MESSAGE_TYPES);
	assign count_new = (rd_valid_q ? ram_rd_data : '0) + CNT_W'(1);
	assign ram_rd_en = rx_fire && phase_q == PH_CK_A;
	assign ram_wr_en = rx_fire && phase_q == PH_CK_B && ck_ok;

	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			PH_HUNT1: begin
				if (rx_byte == SYNC_FIRST) begin
					phase_d = PH_HUNT2;
				end
			end
			PH_HUNT2: begin
				if (rx_byte == SYNC_SECOND) begin
					phase_d = PH_CLASS;
				end else if (rx_byte != SYNC_FIRST) begin
					phase_d = PH_HUNT1;
				end
			end
			PH_CLASS:  phase_d = PH_ID;
			PH_ID:     phase_d = PH_LEN_LO;
			PH_LEN_LO: phase_d = PH_LEN_HI;
			PH_LEN_HI: begin
				if (len_full >= limit_q) begin
					phase_d = PH_HUNT1;
				end else if (len_full == 16'd0) begin
					phase_d = PH_CK_A;
				end else begin
					phase_d = PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				if (pos_next >= len_q) begin
					phase_d = PH_CK_A;
				end
			end
			PH_CK_A: phase_d = PH_CK_B;
			PH_CK_B: phase_d = PH_HUNT1;
			default: phase_d = PH_HUNT1;
		endcase
	end

	always_comb begin
		res_d = '{frame_event: EV_NONE, message_index: 4'd0, payload_valid: 1'b0,
			payload_byte: 8'd0, payload_offset: 16'd0, message_count: '0};
		case (phase_q)
			PH_LEN_HI: begin
				if (len_full >= limit_q) begin
					res_d.frame_event = EV_BADLEN;
				end
			end
			PH_PAYLOAD: begin
				res_d.payload_valid  = 1'b1;
				res_d.payload_byte   = rx_byte;
				res_d.payload_offset = pos_q;
			end
			PH_CK_B: begin
				if (ck_ok) begin
					res_d.frame_event   = known ? EV_KNOWN : EV_UNKNOWN;
					res_d.message_index = known ? 4'(idx_q) : 4'd0;
					res_d.message_count = count_new;
				end else begin
					res_d.frame_event = EV_CKSUM;
				end
			end
			default: begin
				res_d.frame_event = EV_NONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HUNT1;
			limit_q     <= LIMIT_RESET;
			cnt_valid_q <= '0;
			rd_valid_q  <= 1'b0;
			class_q     <= 8'd0;
			len_q       <= 16'd0;
			pos_q       <= 16'd0;
			sum_a_q     <= 8'd0;
			sum_b_q     <= 8'd0;
			rcv_a_q     <= 8'd0;
			idx_q       <= CNT_ADDR_W'(MESSAGE_TYPES);
		end else begin
			if (cfg_wr_en) begin
				limit_q <= cfg_wr_data;
			end
			if (rx_fire) begin
				phase_q <= phase_d;
				case (phase_q)
					PH_HUNT2: begin
						if (rx_byte == SYNC_SECOND) begin
							sum_a_q <= 8'd0;
							sum_b_q <= 8'd0;
						end
					end
					PH_CLASS: begin
						class_q <= rx_byte;
						sum_a_q <= add_a;
						sum_b_q <= add_b;
					end
					PH_ID: begin
						idx_q   <= find_message(class_q, rx_byte);
						sum_a_q <= add_a;
						sum_b_q <= add_b;
					end
					PH_LEN_LO: begin
						len_q   <= {8'd0, rx_byte};
						sum_a_q <= add_a;
						sum_b_q <= add_b;
					end
					PH_LEN_HI: begin
						len_q   <= len_full;
						pos_q   <= 16'd0;
						sum_a_q <= add_a;
						sum_b_q <= add_b;
					end
					PH_PAYLOAD: begin
						pos_q   <= pos_next;
						sum_a_q <= add_a;
						sum_b_q <= add_b;
					end
					PH_CK_A: begin
						rcv_a_q    <= rx_byte;
						rd_valid_q <= cnt_valid_q[idx_q];
					end
					PH_CK_B: begin
						if (ck_ok) begin
							cnt_valid_q[idx_q] <= 1'b1;
						end
					end
					default: begin
						rcv_a_q <= rcv_a_q;
					end
				endcase
			end
		end
	end

	ubxfp_ram #(
		.WIDTH(CNT_W),
		.DEPTH(CNT_ENTRIES)
	) u_cnt_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (idx_q),
		.wr_data (count_new),
		.rd_en   (ram_rd_en),
		.rd_addr (idx_q),
		.rd_data (ram_rd_data)
	);

	ubxfp_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_fire   (rx_fire),
		.in_data   (res_d),
		.in_ready  (rx_ready),
		.out_valid (res_valid),
		.out_data  (res_out),
		.out_ready (res_ready)
	);

	assign frame_event    = res_out.frame_event;
	assign message_index  = res_out.message_index;
	assign payload_valid  = res_out.payload_valid;
	assign payload_byte   = res_out.payload_byte;
	assign payload_offset = res_out.payload_offset;
	assign message_count  = res_out.message_count;

	// The counter memory is never read and written in the same cycle.
	assert property (@(posedge clk) disable iff (!arst_n) !(ram_rd_en && ram_wr_en))
		else $error("counter memory read and write collide");

	assert property (@(posedge clk) disable iff (!arst_n)
		rx_fire && phase_q == PH_CK_A |=> phase_q == PH_CK_B)
		else $error("first checksum byte not followed by the second");

	assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PAYLOAD |-> pos_q < len_q)
		else $error("payload position beyond length");

	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && frame_event == EV_KNOWN |-> message_index < 4'(MESSAGE_TYPES))
		else $error("known frame with index outside table");

	assert property (@(posedge clk) disable iff (!arst_n)
		ram_wr_en |=> cnt_valid_q[$past(idx_q)])
		else $error("counter entry written without its valid bit");

endmodule

### rtl/core/ubxfp_ram.sv
module ubxfp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### rtl/core/ubxfp_skid.sv
module ubxfp_skid import ubxfp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_fire,
	input  res_t in_data,
	output logic in_ready,
	output logic out_valid,
	output res_t out_data,
	input  logic out_ready
);

	logic main_valid_q;
	logic skid_valid_q;
	res_t main_q;
	res_t skid_q;
	logic main_free;

	assign main_free = out_ready || !main_valid_q;
	assign in_ready  = !skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_data  = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (main_free) begin
			main_valid_q <= skid_valid_q || in_fire;
			skid_valid_q <= 1'b0;
		end else if (in_fire) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (main_free) begin
			main_q <= skid_valid_q ? skid_q : in_data;
		end else if (in_fire) begin
			skid_q <= in_data;
		end
	end

endmodule
